FILE: rtl/bsp_pkg.sv
package bsp_pkg;

    // Field widths
    localparam int COORD_W   = 32;
    localparam int PARAM_W   = 17;
    localparam int IDX_W     = 4;
    localparam int ORDER_W   = 2;

    // Stream and configuration port widths
    localparam int S_TDATA_W  = 136;
    localparam int M_TDATA_W  = 96;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;

    // Fixed-point formats
    localparam logic [PARAM_W-1:0] ONE_Q16 = 17'd65536;
    localparam int                 BU_W    = 25;             // Q1.24 basis and weight
    localparam logic [BU_W-1:0]    ONE_Q24 = 25'd16777216;
    localparam int                 BINOM_W = 6;
    localparam int                 ACC_W   = 64;

    // Shared multiplier operand and product widths
    localparam int MUL_A_W = 33;
    localparam int MUL_B_W = 26;
    localparam int MUL_P_W = MUL_A_W + MUL_B_W;

    // Commands carried on the input tuser
    localparam logic CMD_LOAD = 1'b0;
    localparam logic CMD_EVAL = 1'b1;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_ORDER_U  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_ORDER_V  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_ORIGIN_X = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_ORIGIN_Y = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_ORIGIN_Z = 3'd4;

    // Binomial coefficients up to degree seven
    localparam logic [BINOM_W-1:0] BINOM_TABLE [8][8] = '{
        '{6'd1, 6'd0, 6'd0,  6'd0,  6'd0,  6'd0,  6'd0, 6'd0},
        '{6'd1, 6'd1, 6'd0,  6'd0,  6'd0,  6'd0,  6'd0, 6'd0},
        '{6'd1, 6'd2, 6'd1,  6'd0,  6'd0,  6'd0,  6'd0, 6'd0},
        '{6'd1, 6'd3, 6'd3,  6'd1,  6'd0,  6'd0,  6'd0, 6'd0},
        '{6'd1, 6'd4, 6'd6,  6'd4,  6'd1,  6'd0,  6'd0, 6'd0},
        '{6'd1, 6'd5, 6'd10, 6'd10, 6'd5,  6'd1,  6'd0, 6'd0},
        '{6'd1, 6'd6, 6'd15, 6'd20, 6'd15, 6'd6,  6'd1, 6'd0},
        '{6'd1, 6'd7, 6'd21, 6'd35, 6'd35, 6'd21, 6'd7, 6'd1}
    };

    function automatic logic [BINOM_W-1:0] binom(input logic [2:0] n, input logic [2:0] k);
        return BINOM_TABLE[n][k];
    endfunction

endpackage

FILE: rtl/bsp_mul.sv
module bsp_mul (
    input  logic                                  clk,
    input  logic signed [bsp_pkg::MUL_A_W-1:0]    op_a,
    input  logic signed [bsp_pkg::MUL_B_W-1:0]    op_b,
    output logic signed [bsp_pkg::MUL_P_W-1:0]    prod
);
    import bsp_pkg::*;

    logic signed [MUL_P_W-1:0] prod_reg;

    // Multiply signed operands, register the full product
    always_ff @(posedge clk)
    begin
        prod_reg <= MUL_P_W'(op_a) * MUL_P_W'(op_b);
    end

    assign prod = prod_reg;

endmodule

FILE: rtl/bezier_surface_point_eval_core.sv
// Load: the input is ready again in the next cycle.
// Evaluate with degrees nu, nv through one shared registered multiplier: the result is valid
// and the input is ready again in the same cycle; an untaken result delays both.
// Reset (rst_n low, asynchronous) returns to idle, drops the output, and sets both degrees
// to 2 and the origin to zero; control point storage is not cleared.
module bezier_surface_point_eval_core #(
    parameter int MAX_DEGREE  = 3,
    parameter int GRID_POINTS = 16
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    // configuration write port
    input  logic                                 cfg_we,
    input  logic [bsp_pkg::CFG_IDX_W-1:0]        cfg_index,
    input  logic [bsp_pkg::CFG_DATA_W-1:0]       cfg_wdata,
    // input stream
    input  logic                                 s_tvalid,
    output logic                                 s_tready,
    // point_index[3:0], coord_x[35:4], coord_y[67:36], coord_z[99:68],
    // param_u[116:100], param_v[133:117], zero fill[135:134]
    input  logic [bsp_pkg::S_TDATA_W-1:0]        s_tdata,
    // command[0]
    input  logic                                 s_tuser,
    // output stream
    output logic                                 m_tvalid,
    input  logic                                 m_tready,
    // point_x[31:0], point_y[63:32], point_z[95:64]
    output logic [bsp_pkg::M_TDATA_W-1:0]        m_tdata
);
    import bsp_pkg::*;

    localparam int DEG_W = $clog2(MAX_DEGREE + 1);
    localparam int GW    = $clog2((MAX_DEGREE + 1) * (MAX_DEGREE + 1));
    localparam int AW    = $clog2(GRID_POINTS);
    localparam int PT_W  = 3 * COORD_W;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_B_MUL,
        ST_B_WB,
        ST_P_RD,
        ST_P_W,
        ST_P_MX,
        ST_P_MY,
        ST_P_MZ,
        ST_P_ACC,
        ST_FIN
    } state_t;

    // Input field unpacking
    logic [IDX_W-1:0]          in_point_index;
    logic [COORD_W-1:0]        in_coord_x;
    logic [COORD_W-1:0]        in_coord_y;
    logic [COORD_W-1:0]        in_coord_z;
    logic [PARAM_W-1:0]        in_param_u;
    logic [PARAM_W-1:0]        in_param_v;

    assign in_point_index = s_tdata[3:0];
    assign in_coord_x     = s_tdata[35:4];
    assign in_coord_y     = s_tdata[67:36];
    assign in_coord_z     = s_tdata[99:68];
    assign in_param_u     = s_tdata[116:100];
    assign in_param_v     = s_tdata[133:117];

    // Configuration registers
    logic [ORDER_W-1:0]        order_u_reg;
    logic [ORDER_W-1:0]        order_v_reg;
    logic signed [COORD_W-1:0] origin_x_reg;
    logic signed [COORD_W-1:0] origin_y_reg;
    logic signed [COORD_W-1:0] origin_z_reg;

    // Control state
    state_t                    state_reg;
    logic                      dir_reg;      // 0: v basis, 1: u basis
    logic [DEG_W-1:0]          k_reg;
    logic [DEG_W-1:0]          cnt_reg;
    logic [DEG_W-1:0]          i_reg;
    logic [DEG_W-1:0]          j_reg;
    logic [GW-1:0]             g_reg;
    logic                      m_tvalid_reg;

    // Datapath registers
    logic [PARAM_W-1:0]        u_reg;
    logic [PARAM_W-1:0]        v_reg;
    logic [DEG_W-1:0]          nu_reg;
    logic [DEG_W-1:0]          nv_reg;
    logic [BU_W-1:0]           p_reg;
    logic [BU_W-1:0]           bu_reg [MAX_DEGREE+1];
    logic [BU_W-1:0]           bv_reg [MAX_DEGREE+1];
    logic [BU_W-1:0]           w_reg;
    logic [PT_W-1:0]           rd_reg;
    logic signed [ACC_W-1:0]   acc_x_reg;
    logic signed [ACC_W-1:0]   acc_y_reg;
    logic signed [ACC_W-1:0]   acc_z_reg;
    logic [M_TDATA_W-1:0]      m_data_reg;

    // Control point storage
    logic [PT_W-1:0]           mem [GRID_POINTS];

    // Shared multiplier
    logic signed [MUL_A_W-1:0] mul_a;
    logic signed [MUL_B_W-1:0] mul_b;
    logic signed [MUL_P_W-1:0] prod;

    logic                      s_xfer;
    logic                      out_free;
    logic                      load_ok;
    logic                      g_ok;
    logic [DEG_W-1:0]          n_cur;
    logic [PARAM_W-1:0]        t_cur;
    logic [PARAM_W-1:0]        s_cur;
    logic [41:0]               p_sum;
    logic [BU_W-1:0]           p_round;
    logic [50:0]               w_sum;
    logic [BU_W-1:0]           w_round;
    logic signed [ACC_W-1:0]   prod_ext;

    function automatic logic [DEG_W-1:0] deg_clamp(input logic [ORDER_W-1:0] o);
        if (32'(o) > MAX_DEGREE)
            return DEG_W'(MAX_DEGREE);
        return DEG_W'(o);
    endfunction

    function automatic logic [PARAM_W-1:0] param_clamp(input logic [PARAM_W-1:0] t);
        if (t > ONE_Q16)
            return ONE_Q16;
        return t;
    endfunction

    // Round half up from Q.40 to Q15.16 and saturate to 32 bits
    function automatic logic [COORD_W-1:0] round_sat(input logic signed [ACC_W-1:0] acc);
        logic signed [ACC_W-1:0] sum;
        logic signed [39:0]      r;
        sum = acc + ACC_W'(64'sd8388608);
        r   = 40'(sum >>> 24);
        if (r[39:31] == 9'h000 || r[39:31] == 9'h1FF)
            return r[31:0];
        if (r[39])
            return 32'h8000_0000;
        return 32'h7FFF_FFFF;
    endfunction

    assign s_xfer   = s_tvalid && s_tready;
    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_data_reg;
    assign out_free = !m_tvalid_reg || m_tready;
    assign load_ok  = (32'(in_point_index) < GRID_POINTS);
    assign g_ok     = (32'(g_reg) < GRID_POINTS);

    assign n_cur    = dir_reg ? nu_reg : nv_reg;
    assign t_cur    = dir_reg ? u_reg : v_reg;
    assign s_cur    = ONE_Q16 - t_cur;

    // Rounded product of a basis step and of a weight
    assign p_sum    = prod[41:0] + 42'd32768;
    assign p_round  = p_sum[40:16];
    assign w_sum    = prod[50:0] + 51'd8388608;
    assign w_round  = w_sum[48:24];
    assign prod_ext = ACC_W'(prod);

    // Select multiplier operands for the current step
    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        unique case (state_reg)
            ST_B_MUL:
            begin
                mul_a = MUL_A_W'(p_reg);
                if (cnt_reg < k_reg)
                    mul_b = MUL_B_W'(t_cur);
                else if (cnt_reg < n_cur)
                    mul_b = MUL_B_W'(s_cur);
                else
                    mul_b = MUL_B_W'(binom(3'(n_cur), 3'(k_reg)));
            end
            ST_P_RD:
            begin
                mul_a = MUL_A_W'(bu_reg[i_reg]);
                mul_b = MUL_B_W'(bv_reg[j_reg]);
            end
            ST_P_MX:
            begin
                mul_a = MUL_A_W'(signed'(rd_reg[31:0]));
                mul_b = MUL_B_W'(w_reg);
            end
            ST_P_MY:
            begin
                mul_a = MUL_A_W'(signed'(rd_reg[63:32]));
                mul_b = MUL_B_W'(w_reg);
            end
            ST_P_MZ:
            begin
                mul_a = MUL_A_W'(signed'(rd_reg[95:64]));
                mul_b = MUL_B_W'(w_reg);
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    bsp_mul u_mul (
        .clk  (clk),
        .op_a (mul_a),
        .op_b (mul_b),
        .prod (prod)
    );

    // Configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            order_u_reg  <= 2'd2;
            order_v_reg  <= 2'd2;
            origin_x_reg <= '0;
            origin_y_reg <= '0;
            origin_z_reg <= '0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_ORDER_U:  order_u_reg  <= cfg_wdata[ORDER_W-1:0];
                REG_ORDER_V:  order_v_reg  <= cfg_wdata[ORDER_W-1:0];
                REG_ORIGIN_X: origin_x_reg <= cfg_wdata;
                REG_ORIGIN_Y: origin_y_reg <= cfg_wdata;
                REG_ORIGIN_Z: origin_z_reg <= cfg_wdata;
                default: ;
            endcase
        end
    end

    // Sequencer: basis values for v, then u, then one pass over the grid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            dir_reg      <= 1'b0;
            k_reg        <= '0;
            cnt_reg      <= '0;
            i_reg        <= '0;
            j_reg        <= '0;
            g_reg        <= '0;
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            // raise the result when the pass finishes, drop it once taken
            if (state_reg == ST_FIN && out_free)
                m_tvalid_reg <= 1'b1;
            else if (m_tvalid_reg && m_tready)
                m_tvalid_reg <= 1'b0;

            unique case (state_reg)
                ST_IDLE:
                begin
                    if (s_xfer && s_tuser == CMD_EVAL)
                    begin
                        dir_reg   <= 1'b0;
                        k_reg     <= '0;
                        cnt_reg   <= '0;
                        state_reg <= ST_B_MUL;
                    end
                end
                ST_B_MUL:
                begin
                    state_reg <= ST_B_WB;
                end
                ST_B_WB:
                begin
                    if (cnt_reg != n_cur)
                    begin
                        cnt_reg   <= cnt_reg + 1'b1;
                        state_reg <= ST_B_MUL;
                    end
                    else
                    begin
                        cnt_reg <= '0;
                        if (k_reg != n_cur)
                        begin
                            k_reg     <= k_reg + 1'b1;
                            state_reg <= ST_B_MUL;
                        end
                        else if (!dir_reg)
                        begin
                            dir_reg   <= 1'b1;
                            k_reg     <= '0;
                            state_reg <= ST_B_MUL;
                        end
                        else
                        begin
                            i_reg     <= '0;
                            j_reg     <= '0;
                            g_reg     <= '0;
                            state_reg <= ST_P_RD;
                        end
                    end
                end
                ST_P_RD:  state_reg <= ST_P_W;
                ST_P_W:   state_reg <= ST_P_MX;
                ST_P_MX:  state_reg <= ST_P_MY;
                ST_P_MY:  state_reg <= ST_P_MZ;
                ST_P_MZ:  state_reg <= ST_P_ACC;
                ST_P_ACC:
                begin
                    // advance row-major over the grid
                    g_reg <= g_reg + 1'b1;
                    if (j_reg != nv_reg)
                    begin
                        j_reg     <= j_reg + 1'b1;
                        state_reg <= ST_P_RD;
                    end
                    else if (i_reg != nu_reg)
                    begin
                        j_reg     <= '0;
                        i_reg     <= i_reg + 1'b1;
                        state_reg <= ST_P_RD;
                    end
                    else
                    begin
                        state_reg <= ST_FIN;
                    end
                end
                ST_FIN:
                begin
                    if (out_free)
                        state_reg <= ST_IDLE;
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    // Control point storage: write on load, registered read during the grid pass
    always_ff @(posedge clk)
    begin
        if (s_xfer && s_tuser == CMD_LOAD && load_ok)
            mem[AW'(in_point_index)] <= {in_coord_z, in_coord_y, in_coord_x};
        if (state_reg == ST_P_RD)
            rd_reg <= mem[AW'(g_reg)];
    end

    // Datapath registers
    always_ff @(posedge clk)
    begin
        // capture the evaluate operands
        if (state_reg == ST_IDLE && s_xfer && s_tuser == CMD_EVAL)
        begin
            u_reg     <= param_clamp(in_param_u);
            v_reg     <= param_clamp(in_param_v);
            nu_reg    <= deg_clamp(order_u_reg);
            nv_reg    <= deg_clamp(order_v_reg);
            p_reg     <= ONE_Q24;
            acc_x_reg <= {{8{origin_x_reg[COORD_W-1]}}, origin_x_reg, 24'd0};
            acc_y_reg <= {{8{origin_y_reg[COORD_W-1]}}, origin_y_reg, 24'd0};
            acc_z_reg <= {{8{origin_z_reg[COORD_W-1]}}, origin_z_reg, 24'd0};
        end

        // basis power steps, then the binomial scale
        if (state_reg == ST_B_WB)
        begin
            if (cnt_reg != n_cur)
            begin
                p_reg <= p_round;
            end
            else
            begin
                p_reg <= ONE_Q24;
                if (dir_reg)
                    bu_reg[k_reg] <= prod[BU_W-1:0];
                else
                    bv_reg[k_reg] <= prod[BU_W-1:0];
            end
        end

        // two-dimensional weight
        if (state_reg == ST_P_W)
            w_reg <= w_round;

        // accumulate in-range grid positions only
        if (state_reg == ST_P_MY && g_ok)
            acc_x_reg <= acc_x_reg + prod_ext;
        if (state_reg == ST_P_MZ && g_ok)
            acc_y_reg <= acc_y_reg + prod_ext;
        if (state_reg == ST_P_ACC && g_ok)
            acc_z_reg <= acc_z_reg + prod_ext;

        // hold the result until the output side takes it
        if (state_reg == ST_FIN && out_free)
            m_data_reg <= {round_sat(acc_z_reg), round_sat(acc_y_reg), round_sat(acc_x_reg)};
    end

endmodule

FILE: rtl/bsp_checker.sv
module bsp_checker (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           s_tvalid,
    input  logic                           s_tready,
    input  logic                           s_tuser,
    input  logic                           m_tvalid,
    input  logic                           m_tready,
    input  logic [bsp_pkg::M_TDATA_W-1:0]  m_tdata
);
    import bsp_pkg::*;

    // An evaluate keeps the input side busy in the following cycle
    assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready && s_tuser == CMD_EVAL |=> !s_tready)
        else $error("input ready right after an evaluate transfer");

    // A load completes in its transfer cycle
    assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready && s_tuser == CMD_LOAD |=> s_tready)
        else $error("input not ready after a load transfer");

    // A result never appears right after an input transfer
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_tvalid) |-> !$past(s_tvalid && s_tready))
        else $error("result follows an input transfer too soon");

    // A stalled result holds
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("stalled result changed or dropped");

endmodule

bind bezier_surface_point_eval_core bsp_checker u_bsp_checker (.*);
